>>> design/bsalu_pkg.sv
// Package: opcode and shift codes, flag positions and word types for the data-processing ALU.
package bsalu_pkg;

	localparam int unsigned DataW = 32;

	// ALU opcodes, instruction bits 24:21
	typedef enum logic [3:0] {
		OP_AND = 4'h0,
		OP_EOR = 4'h1,
		OP_SUB = 4'h2,
		OP_RSB = 4'h3,
		OP_ADD = 4'h4,
		OP_ADC = 4'h5,
		OP_SBC = 4'h6,
		OP_RSC = 4'h7,
		OP_TST = 4'h8,
		OP_TEQ = 4'h9,
		OP_CMP = 4'hA,
		OP_CMN = 4'hB,
		OP_ORR = 4'hC,
		OP_MOV = 4'hD,
		OP_BIC = 4'hE,
		OP_MVN = 4'hF
	} opcode_t;

	// shift types, instruction bits 6:5
	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	// NZCV bit positions
	localparam int unsigned FlagN = 3;
	localparam int unsigned FlagZ = 2;
	localparam int unsigned FlagC = 1;
	localparam int unsigned FlagV = 0;

	localparam logic [3:0] RegPc = 4'd15;
	localparam logic [7:0] ShiftFull = 8'd32;

	// one input word
	typedef struct packed {
		logic [DataW-1:0] instruction;
		logic [DataW-1:0] first_operand;
		logic [DataW-1:0] shift_source;
		logic [DataW-1:0] shift_amount_reg;
		logic [3:0]       flags_in;
		logic             mode_has_saved_status;
	} in_word_t;

	// one result word
	typedef struct packed {
		logic [DataW-1:0] alu_result;
		logic [3:0]       dest_index;
		logic             write_dest;
		logic [3:0]       flags_out;
		logic             restore_status;
	} out_word_t;

	// rotate right by 0..31
	function automatic logic [DataW-1:0] ror32(input logic [DataW-1:0] v, input logic [4:0] r);
		logic [2*DataW-1:0] d;
		d = {v, v} >> r;
		return d[DataW-1:0];
	endfunction

endpackage

>>> design/bsalu_in_if.sv
// Interface: input channel carrying one instruction word and its operands.
interface bsalu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [31:0] first_operand;
	logic [31:0] shift_source;
	logic [31:0] shift_amount_reg;
	logic [3:0]  flags_in;
	logic        mode_has_saved_status;

	modport source (
		output valid, instruction, first_operand, shift_source, shift_amount_reg,
		output flags_in, mode_has_saved_status,
		input  ready
	);
	modport sink (
		input  valid, instruction, first_operand, shift_source, shift_amount_reg,
		input  flags_in, mode_has_saved_status,
		output ready
	);
endinterface

>>> design/bsalu_out_if.sv
// Interface: result channel carrying one executed data-processing word.
interface bsalu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] alu_result;
	logic [3:0]  dest_index;
	logic        write_dest;
	logic [3:0]  flags_out;
	logic        restore_status;

	modport source (
		output valid, alu_result, dest_index, write_dest, flags_out, restore_status,
		input  ready
	);
	modport sink (
		input  valid, alu_result, dest_index, write_dest, flags_out, restore_status,
		output ready
	);
endinterface

>>> design/barrel_shifter_alu_data_processing_core.sv
// Top level: ARM data-processing execute stage, barrel shifter plus 32-bit ALU.
//
//   channel  modport  moves                                    handshake
//   insn     sink     instruction, three operands, NZCV, mode  valid/ready
//   result   source   result, Rd, write enable, NZCV, restore  valid/ready
//
// An input register, then shifter and ALU in one pass into the result
// register. One word is taken every cycle while the result channel is not
// stalled; the shifter plus the 32-bit adder between the two registers set
// the clock period. Reset clears only the two valid bits. A stalled result
// holds the result register, and the input register still takes a word while
// the result register can drain in the same cycle.
module barrel_shifter_alu_data_processing_core
	import bsalu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	bsalu_in_if.sink      insn,
	bsalu_out_if.source   result
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	out_word_t word_s2;
	out_word_t word_next;
	logic      load_s2;

	// pipeline control
	assign load_s2   = !valid_s2 || result.ready;
	assign insn.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (insn.ready) begin
				valid_s1 <= insn.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (insn.ready && insn.valid) begin
			word_s1.instruction           <= insn.instruction;
			word_s1.first_operand         <= insn.first_operand;
			word_s1.shift_source          <= insn.shift_source;
			word_s1.shift_amount_reg      <= insn.shift_amount_reg;
			word_s1.flags_in              <= insn.flags_in;
			word_s1.mode_has_saved_status <= insn.mode_has_saved_status;
		end
	end

	// decode
	logic [31:0] ir;
	logic [31:0] rm;
	logic [31:0] rn;
	logic        cin;
	shift_t      sh_type;
	logic [4:0]  sh_imm;
	logic [7:0]  amt;
	logic [4:0]  rot;
	opcode_t     op;

	assign ir      = word_s1.instruction;
	assign rm      = word_s1.shift_source;
	assign rn      = word_s1.first_operand;
	assign cin     = word_s1.flags_in[FlagC];
	assign sh_type = shift_t'(ir[6:5]);
	assign sh_imm  = ir[11:7];
	assign amt     = word_s1.shift_amount_reg[7:0];
	assign rot     = {ir[11:8], 1'b0};
	assign op      = opcode_t'(ir[24:21]);

	// barrel shifter: operand and shifter carry
	logic [31:0] b_op;
	logic        sc;

	always_comb begin
		b_op = rm;
		sc   = cin;
		if (ir[25]) begin
			// rotated immediate
			b_op = ror32({24'd0, ir[7:0]}, rot);
			if (rot != 5'd0) begin
				sc = b_op[31];
			end
		end else if (!ir[4]) begin
			// shift by immediate
			case (sh_type)
				SH_LSL: begin
					if (sh_imm != 5'd0) begin
						sc   = rm[5'(5'd0 - sh_imm)];
						b_op = rm << sh_imm;
					end
				end
				SH_LSR: begin
					if (sh_imm == 5'd0) begin
						sc   = rm[31];
						b_op = '0;
					end else begin
						sc   = rm[5'(sh_imm - 5'd1)];
						b_op = rm >> sh_imm;
					end
				end
				SH_ASR: begin
					if (sh_imm == 5'd0) begin
						sc   = rm[31];
						b_op = {32{rm[31]}};
					end else begin
						sc   = rm[5'(sh_imm - 5'd1)];
						b_op = 32'($signed(rm) >>> sh_imm);
					end
				end
				default: begin
					if (sh_imm == 5'd0) begin
						// RRX
						sc   = rm[0];
						b_op = {cin, rm[31:1]};
					end else begin
						sc   = rm[5'(sh_imm - 5'd1)];
						b_op = ror32(rm, sh_imm);
					end
				end
			endcase
		end else if (amt != 8'd0) begin
			// shift by register byte
			case (sh_type)
				SH_LSL: begin
					if (amt < ShiftFull) begin
						sc   = rm[5'(5'd0 - amt[4:0])];
						b_op = rm << amt[4:0];
					end else begin
						sc   = (amt == ShiftFull) ? rm[0] : 1'b0;
						b_op = '0;
					end
				end
				SH_LSR: begin
					if (amt < ShiftFull) begin
						sc   = rm[5'(amt[4:0] - 5'd1)];
						b_op = rm >> amt[4:0];
					end else begin
						sc   = (amt == ShiftFull) ? rm[31] : 1'b0;
						b_op = '0;
					end
				end
				SH_ASR: begin
					if (amt < ShiftFull) begin
						sc   = rm[5'(amt[4:0] - 5'd1)];
						b_op = 32'($signed(rm) >>> amt[4:0]);
					end else begin
						sc   = rm[31];
						b_op = {32{rm[31]}};
					end
				end
				default: begin
					if (amt[4:0] == 5'd0) begin
						sc   = rm[31];
						b_op = rm;
					end else begin
						sc   = rm[5'(amt[4:0] - 5'd1)];
						b_op = ror32(rm, amt[4:0]);
					end
				end
			endcase
		end
	end

	// ALU operand select
	logic        arith;
	logic [31:0] ax;
	logic [31:0] ay;
	logic        aci;
	logic [31:0] logic_res;

	always_comb begin
		arith     = 1'b1;
		ax        = rn;
		ay        = b_op;
		aci       = 1'b0;
		logic_res = '0;
		case (op) inside
			OP_AND, OP_TST: begin arith = 1'b0; logic_res = rn & b_op; end
			OP_EOR, OP_TEQ: begin arith = 1'b0; logic_res = rn ^ b_op; end
			OP_SUB, OP_CMP: begin ay = ~b_op; aci = 1'b1; end
			OP_RSB:         begin ax = b_op; ay = ~rn; aci = 1'b1; end
			OP_ADD, OP_CMN: begin aci = 1'b0; end
			OP_ADC:         begin aci = cin; end
			OP_SBC:         begin ay = ~b_op; aci = cin; end
			OP_RSC:         begin ax = b_op; ay = ~rn; aci = cin; end
			OP_ORR:         begin arith = 1'b0; logic_res = rn | b_op; end
			OP_MOV:         begin arith = 1'b0; logic_res = b_op; end
			OP_BIC:         begin arith = 1'b0; logic_res = rn & ~b_op; end
			default:        begin arith = 1'b0; logic_res = ~b_op; end
		endcase
	end

	// adder and flags
	logic [32:0] sum;
	logic [31:0] res;
	logic [3:0]  nf;
	logic        compare;
	logic        set_s;
	logic        rd_pc;

	assign sum     = {1'b0, ax} + {1'b0, ay} + {32'd0, aci};
	assign res     = arith ? sum[31:0] : logic_res;
	assign compare = (ir[24:23] == 2'b10);
	assign set_s   = ir[20];
	assign rd_pc   = (ir[15:12] == RegPc);

	always_comb begin
		nf        = '0;
		nf[FlagN] = res[31];
		nf[FlagZ] = (res == 32'd0);
		if (arith) begin
			nf[FlagC] = sum[32];
			nf[FlagV] = ((ax[31] ^ res[31]) & (ay[31] ^ res[31]));
		end else begin
			nf[FlagC] = sc;
			nf[FlagV] = word_s1.flags_in[FlagV];
		end
	end

	// result word
	always_comb begin
		word_next.alu_result     = compare ? 32'd0 : res;
		word_next.dest_index     = ir[15:12];
		word_next.write_dest     = !compare;
		word_next.restore_status = !compare && set_s && rd_pc && word_s1.mode_has_saved_status;
		if (compare || (set_s && !rd_pc)) begin
			word_next.flags_out = nf;
		end else begin
			word_next.flags_out = word_s1.flags_in;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			word_s2 <= word_next;
		end
	end

	assign result.valid          = valid_s2;
	assign result.alu_result     = word_s2.alu_result;
	assign result.dest_index     = word_s2.dest_index;
	assign result.write_dest     = word_s2.write_dest;
	assign result.flags_out      = word_s2.flags_out;
	assign result.restore_status = word_s2.restore_status;

	// checks
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!insn.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled while pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(insn.valid && insn.ready) |=> valid_s1)
		else $error("accepted word lost from input register");

	a_compare_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.write_dest) |->
		(result.alu_result == 32'd0 && !result.restore_status))
		else $error("compare result writes or restores");

	a_restore_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.restore_status) |-> (result.dest_index == RegPc))
		else $error("status restore without PC destination");

endmodule
